/* rtl/qoi_enc_pkg.sv */
// Types, op codes and the index hash shared by the QOI RGB pixel encoder.
// No dependencies; all rtl/ files but qoi_enc_ram import this package.
`default_nettype none

package qoi_enc_pkg;

    localparam int unsigned IndexSize   = 64;
    localparam int unsigned IndexW      = $clog2(IndexSize);
    localparam int unsigned AlphaFull   = 255;
    localparam int unsigned AlphaWeight = 11;
    localparam int unsigned MaxBytes    = 5;
    localparam int unsigned CountW      = $clog2(MaxBytes + 1);
    localparam int unsigned SlotW       = $clog2(MaxBytes);

    localparam logic [7:0] OpIndex = 8'h00;
    localparam logic [7:0] OpDiff  = 8'h40;
    localparam logic [7:0] OpLuma  = 8'h80;
    localparam logic [7:0] OpRun   = 8'hC0;
    localparam logic [7:0] OpRgb   = 8'hFE;

    localparam logic [5:0] RunLimit = 6'd62;

    // Alpha term of the hash folded to a constant modulo the index size.
    localparam logic [IndexW-1:0] HashBias =
        IndexW'((AlphaFull * AlphaWeight) % IndexSize);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } code_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Bytes caused by one pixel, first byte in slot 0.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CountW-1:0]        count;
    } op_rec_t;

    typedef struct packed {
        logic    valid;
        op_rec_t rec;
    } op_push_t;

    typedef struct packed {
        logic    valid;
        op_rec_t rec;
    } op_head_t;

    // (r*3 + g*5 + b*7 + 255*11) mod 64, carried out in IndexW bits.
    function automatic logic [IndexW-1:0] index_hash(input rgb_t px);
        logic [IndexW-1:0] h;
        h = px.red[IndexW-1:0] * IndexW'(3) + px.green[IndexW-1:0] * IndexW'(5)
          + px.blue[IndexW-1:0] * IndexW'(7) + HashBias;
        return h;
    endfunction

    function automatic logic [7:0] run_byte(input logic [5:0] len);
        return OpRun | {2'b00, len - 6'd1};
    endfunction

endpackage

`default_nettype wire

/* rtl/qoi_enc_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-old on collision).
// No dependencies.
`default_nettype none

module qoi_enc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/qoi_enc_front.sv */
// Front part: accepts pixels, looks up the colour index, classifies each pixel
// into the QOI bytes it causes. Depends on qoi_enc_pkg and qoi_enc_ram.
`default_nettype none

module qoi_enc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_stall,
    input  wire qoi_enc_pkg::pixel_t  pix,
    output qoi_enc_pkg::op_push_t     push,
    input  wire logic                 push_ready
);

    import qoi_enc_pkg::*;

    logic              accept;
    logic [IndexW-1:0] in_pos;
    rgb_t              in_rgb;

    logic              s1_valid_reg;
    pixel_t            s1_pix_reg;
    logic [IndexW-1:0] s1_pos_reg;
    rgb_t              cur_rgb;

    rgb_t              prev_reg;
    rgb_t              prev_next;
    logic [5:0]        run_reg;
    logic [5:0]        run_next;
    logic [5:0]        run_inc;
    logic [IndexSize-1:0] slot_valid_reg;

    logic              fwd_hit_reg;
    rgb_t              fwd_rgb_reg;
    rgb_t              ram_rdata;
    rgb_t              entry;

    logic              same;
    logic              hit;
    logic              miss_write;
    logic              wr_en;
    logic              s1_fire;

    logic signed [7:0] dr;
    logic signed [7:0] dg;
    logic signed [7:0] db;
    logic signed [8:0] rg;
    logic signed [8:0] bg;
    logic              diff_ok;
    logic              luma_ok;

    logic [MaxBytes-1:0][7:0] rec_bytes;
    logic [CountW-1:0]        rec_count;

    assign in_rgb  = '{red: pix.red, green: pix.green, blue: pix.blue};
    assign in_pos  = index_hash(in_rgb);
    assign cur_rgb = '{red: s1_pix_reg.red, green: s1_pix_reg.green,
                       blue: s1_pix_reg.blue};

    assign s1_fire   = s1_valid_reg && ((rec_count == '0) || push_ready);
    assign pix_stall = s1_valid_reg && !s1_fire;
    assign accept    = pix_valid && !pix_stall;

    qoi_enc_ram #(
        .Width ($bits(rgb_t)),
        .Depth (IndexSize)
    ) u_index_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_pos_reg),
        .wdata (cur_rgb),
        .re    (accept),
        .raddr (in_pos),
        .rdata (ram_rdata)
    );

    // A write on the edge that issued the read is not in the read data; take it from here.
    assign entry = fwd_hit_reg ? fwd_rgb_reg : ram_rdata;
    assign same  = (cur_rgb == prev_reg);
    assign hit   = slot_valid_reg[s1_pos_reg] && (entry == cur_rgb);
    assign wr_en = s1_fire && miss_write;

    assign dr = cur_rgb.red   - prev_reg.red;
    assign dg = cur_rgb.green - prev_reg.green;
    assign db = cur_rgb.blue  - prev_reg.blue;
    assign rg = {dr[7], dr} - {dg[7], dg};
    assign bg = {db[7], db} - {dg[7], dg};

    assign diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
                  && (db >= -8'sd2) && (db <= 8'sd1);
    assign luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (rg >= -9'sd8) && (rg <= 9'sd7)
                  && (bg >= -9'sd8) && (bg <= 9'sd7);
    assign run_inc = run_reg + 6'd1;

    always_comb
    begin
        rec_bytes  = '0;
        rec_count  = '0;
        run_next   = run_reg;
        prev_next  = prev_reg;
        miss_write = 1'b0;
        if (same)
        begin
            run_next = run_inc;
            if (run_inc == RunLimit)
            begin
                rec_bytes[SlotW'(rec_count)] = run_byte(run_inc);
                rec_count = rec_count + CountW'(1);
                run_next  = '0;
            end
        end
        else
        begin
            prev_next = cur_rgb;
            run_next  = '0;
            if (run_reg != '0)
            begin
                rec_bytes[SlotW'(rec_count)] = run_byte(run_reg);
                rec_count = rec_count + CountW'(1);
            end
            if (hit)
            begin
                rec_bytes[SlotW'(rec_count)] = OpIndex | {2'b00, s1_pos_reg};
                rec_count = rec_count + CountW'(1);
            end
            else
            begin
                miss_write = 1'b1;
                if (diff_ok)
                begin
                    rec_bytes[SlotW'(rec_count)] = OpDiff | {2'b00, dr[1:0] + 2'd2,
                                                   dg[1:0] + 2'd2, db[1:0] + 2'd2};
                    rec_count = rec_count + CountW'(1);
                end
                else if (luma_ok)
                begin
                    rec_bytes[SlotW'(rec_count)] = OpLuma | {2'b00, dg[5:0] + 6'd32};
                    rec_count = rec_count + CountW'(1);
                    rec_bytes[SlotW'(rec_count)] = {rg[3:0] + 4'd8, bg[3:0] + 4'd8};
                    rec_count = rec_count + CountW'(1);
                end
                else
                begin
                    rec_bytes[SlotW'(rec_count)] = OpRgb;
                    rec_count = rec_count + CountW'(1);
                    rec_bytes[SlotW'(rec_count)] = cur_rgb.red;
                    rec_count = rec_count + CountW'(1);
                    rec_bytes[SlotW'(rec_count)] = cur_rgb.green;
                    rec_count = rec_count + CountW'(1);
                    rec_bytes[SlotW'(rec_count)] = cur_rgb.blue;
                    rec_count = rec_count + CountW'(1);
                end
            end
        end
        // End of image: flush what is still pending, then drop all state.
        if (s1_pix_reg.last_pixel)
        begin
            if (run_next != '0)
            begin
                rec_bytes[SlotW'(rec_count)] = run_byte(run_next);
                rec_count = rec_count + CountW'(1);
            end
            run_next  = '0;
            prev_next = '0;
        end
    end

    assign push.valid     = s1_fire && (rec_count != '0);
    assign push.rec.bytes = rec_bytes;
    assign push.rec.count = rec_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prev_reg       <= '0;
            run_reg        <= '0;
            slot_valid_reg <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s1_pos_reg == in_pos);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                prev_reg <= prev_next;
                run_reg  <= run_next;
                if (s1_pix_reg.last_pixel)
                begin
                    slot_valid_reg <= '0;
                end
                else if (miss_write)
                begin
                    slot_valid_reg[s1_pos_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix;
            s1_pos_reg  <= in_pos;
            fwd_rgb_reg <= cur_rgb;
        end
    end

endmodule

`default_nettype wire

/* rtl/qoi_enc_queue.sv */
// Short queue of op records between the classifier and the byte serializer.
// Depends on qoi_enc_pkg.
`default_nettype none

module qoi_enc_queue #(
    parameter int unsigned Depth = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire qoi_enc_pkg::op_push_t push,
    output logic                       push_ready,
    output qoi_enc_pkg::op_head_t      head,
    input  wire logic                  pop
);

    import qoi_enc_pkg::*;

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    op_rec_t         entry_reg [Depth];
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] wr_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.rec   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

`default_nettype wire

/* rtl/qoi_enc_back.sv */
// Back part: walks the bytes of the queue head into the output register.
// Depends on qoi_enc_pkg.
`default_nettype none

module qoi_enc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire qoi_enc_pkg::op_head_t head,
    output logic                       pop,
    output logic                       code_valid,
    input  wire logic                  code_stall,
    output qoi_enc_pkg::code_t         code
);

    import qoi_enc_pkg::*;

    logic [SlotW-1:0] slot_reg;
    logic             out_valid_reg;
    code_t            out_reg;
    logic             advance;
    logic             load;
    logic             final_byte;

    assign advance    = !out_valid_reg || !code_stall;
    assign load       = advance && head.valid;
    assign final_byte = (CountW'(slot_reg) + CountW'(1)) == head.rec.count;
    assign pop        = load && final_byte;
    assign code_valid = out_valid_reg;
    assign code       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= head.valid;
            end
            if (load)
            begin
                slot_reg <= final_byte ? '0 : slot_reg + SlotW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte     <= head.rec.bytes[slot_reg];
            out_reg.last_of_item <= final_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/qoi_rgb_pixel_encoder_unit.sv */
// Top level of the QOI RGB pixel encoder: front classifier, op queue, byte serializer.
// Depends on qoi_enc_pkg, qoi_enc_front, qoi_enc_queue, qoi_enc_back.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------
//   pix      | in        | pix_valid / pix_stall | red, green, blue, last_pixel
//   code     | out       | code_valid/code_stall | out_byte, last_of_item
//
// Rate: one pixel a cycle while each pixel causes at most one byte and code_stall is low;
// a pixel that causes k bytes holds the byte serializer for its k bytes (one output byte per cycle).
// Path: a pixel goes through the front stage register, a queue entry, then the output register.
// Reset: asynchronous; the 64 index slots carry valid flops cleared at once, so no
// clearing pass; the marked last pixel clears them the same way.
// Stalls: the queue lets the classifier keep running while the output is stalled,
// and the input stalls only once the queue fills.
`default_nettype none

module qoi_rgb_pixel_encoder_unit #(
    parameter int unsigned QueueDepth = 2    // op records in flight, 2 or more
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_stall,
    input  wire qoi_enc_pkg::pixel_t  pix,
    output logic                      code_valid,
    input  wire logic                 code_stall,
    output qoi_enc_pkg::code_t        code
);

    import qoi_enc_pkg::*;

    op_push_t push;
    logic     push_ready;
    op_head_t head;
    logic     pop;

    // Front: input stage, index lookup with write forwarding, run/index/diff/luma/rgb choice.
    qoi_enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .push       (push),
        .push_ready (push_ready)
    );

    // Queue: holds whole op records so the front never waits on single bytes.
    qoi_enc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Back: one byte per cycle to the output reg while unstalled; mark the final byte.
    qoi_enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

    // A record pushed while the queue is full would be lost.
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> push_ready)
        else $error("op record pushed into a full queue");

    // Only non-empty records of at most five bytes may reach the serializer.
    assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (head.rec.count != '0) && (head.rec.count <= CountW'(MaxBytes)))
        else $error("queue head holds a bad byte count");

    // The serializer pops only a present record.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from an empty queue");

    // A popped record's byte goes out flagged as the final byte of its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> code_valid && code.last_of_item)
        else $error("final byte of a pixel not flagged");

endmodule

`default_nettype wire

/* tb/sv/qoi_enc_tb_pkg.sv */
// Byte-stream scoreboard for the QOI RGB pixel encoder testbench.
// Depends on qoi_enc_pkg for the pixel and code types and the op constants.

package qoi_enc_tb_pkg;

    import qoi_enc_pkg::*;

    class qoi_stream_scoreboard;

        rgb_t        last_rgb;
        int unsigned run_count;
        rgb_t        slot_rgb  [IndexSize];
        bit          slot_full [IndexSize];
        code_t       byte_queue[$];
        int unsigned mismatches;
        int unsigned bytes_checked;
        int unsigned pixels_noted;

        function new();
            clear_state();
            mismatches    = 0;
            bytes_checked = 0;
            pixels_noted  = 0;
        endfunction

        function void clear_state();
            last_rgb  = '0;
            run_count = 0;
            foreach (slot_full[i])
            begin
                slot_full[i] = 1'b0;
                slot_rgb[i]  = '0;
            end
        endfunction

        // Channel change wrapped into -128..127.
        function int channel_step(logic [7:0] now, logic [7:0] was);
            logic [7:0] t;
            t = now - was;
            return (t > 8'd127) ? int'(t) - 256 : int'(t);
        endfunction

        // Work out the bytes this pixel causes and queue them.
        function void note_pixel(pixel_t px);
            rgb_t       now;
            int         pos;
            int         dr, dg, db, rg, bg;
            logic [7:0] fresh[$];
            now = {px.red, px.green, px.blue};
            if (now == last_rgb)
            begin
                run_count++;
                if (run_count == RunLimit)
                begin
                    fresh.push_back(OpRun | 8'(run_count - 1));
                    run_count = 0;
                end
            end
            else
            begin
                if (run_count > 0)
                begin
                    fresh.push_back(OpRun | 8'(run_count - 1));
                    run_count = 0;
                end
                pos = (int'(now.red) * 3 + int'(now.green) * 5 + int'(now.blue) * 7
                       + AlphaFull * AlphaWeight) % IndexSize;
                if (slot_full[pos] && slot_rgb[pos] == now)
                    fresh.push_back(OpIndex | 8'(pos));
                else
                begin
                    dr = channel_step(now.red,   last_rgb.red);
                    dg = channel_step(now.green, last_rgb.green);
                    db = channel_step(now.blue,  last_rgb.blue);
                    rg = dr - dg;
                    bg = db - dg;
                    slot_rgb[pos]  = now;
                    slot_full[pos] = 1'b1;
                    if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1)
                        fresh.push_back(OpDiff | 8'(((dr + 2) << 4) | ((dg + 2) << 2)
                                                    | (db + 2)));
                    else if (dg >= -32 && dg <= 31 && rg >= -8 && rg <= 7
                             && bg >= -8 && bg <= 7)
                    begin
                        fresh.push_back(OpLuma | 8'(dg + 32));
                        fresh.push_back(8'(((rg + 8) << 4) | (bg + 8)));
                    end
                    else
                    begin
                        fresh.push_back(OpRgb);
                        fresh.push_back(now.red);
                        fresh.push_back(now.green);
                        fresh.push_back(now.blue);
                    end
                end
                last_rgb = now;
            end
            if (px.last_pixel)
            begin
                if (run_count > 0)
                    fresh.push_back(OpRun | 8'(run_count - 1));
                clear_state();
            end
            foreach (fresh[i])
                byte_queue.push_back('{out_byte: fresh[i],
                                       last_of_item: 1'(i == fresh.size() - 1)});
            pixels_noted++;
        endfunction

        function void flag(string what, code_t want, code_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("byte %0d: %s mismatch: expected %02h/%0b, got %02h/%0b",
                         bytes_checked, what, want.out_byte, want.last_of_item,
                         got.out_byte, got.last_of_item);
        endfunction

        // Compare one accepted byte with the oldest queued one.
        function void check_code(code_t got);
            code_t want;
            string what;
            bytes_checked++;
            if (byte_queue.size() == 0)
            begin
                flag("unexpected byte", '0, got);
                return;
            end
            want = byte_queue.pop_front();
            what = "";
            if (got.out_byte !== want.out_byte)
                what = "out_byte";
            if (got.last_of_item !== want.last_of_item)
                what = {what, (what == "") ? "" : "+", "last_of_item"};
            if (what != "")
                flag(what, want, got);
        endfunction

        function int outstanding();
            return byte_queue.size();
        endfunction

    endclass

endpackage

/* tb/sv/tb_qoi_rgb_pixel_encoder_unit.sv */
// Self-checking testbench for qoi_rgb_pixel_encoder_unit: directed pixels, then random images.
// Depends on qoi_enc_pkg (RTL) and qoi_enc_tb_pkg (byte-stream scoreboard).

module tb_qoi_rgb_pixel_encoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import qoi_enc_pkg::*;
    import qoi_enc_tb_pkg::*;

    // Kinds of colour the image generator can pick next.
    typedef enum int {PickDiff, PickLuma, PickEdge, PickRecall, PickAny} pick_kind_t;

    logic   clk;
    logic   rst_n;
    logic   pix_valid;
    logic   pix_stall;
    pixel_t pix;
    logic   code_valid;
    logic   code_stall;
    code_t  code;

    qoi_stream_scoreboard sb = new();

    // Generator view of the image: previous colour and a short palette for index hits.
    rgb_t        src_prev    = '0;
    rgb_t        recent[$];
    bit          calm_in     = 1'b0;
    bit          calm_out    = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned images_sent = 0;
    int unsigned long_runs   = 0;

    qoi_rgb_pixel_encoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: the slowest correct run is well under a tenth of this.
    initial
    begin
        #5ms;
        $display("[qoi_rgb_pixel_encoder_unit] ERROR");
        $finish;
    end

    function automatic pixel_t make_pixel(input rgb_t c, input logic last);
        return {c.red, c.green, c.blue, last};
    endfunction

    // Pick the next colour relative to the previous one.
    function automatic rgb_t pick_colour(input pick_kind_t kind);
        rgb_t c;
        int   dg, rgoff, bgoff;
        c = src_prev;
        case (kind)
            PickDiff:
            begin
                c.red   = src_prev.red   + 8'($urandom_range(0, 3)) - 8'd2;
                c.green = src_prev.green + 8'($urandom_range(0, 3)) - 8'd2;
                c.blue  = src_prev.blue  + 8'($urandom_range(0, 3)) - 8'd2;
            end
            PickLuma, PickEdge:
            begin
                if (kind == PickLuma)
                begin
                    dg    = int'($urandom_range(0, 63)) - 32;
                    rgoff = int'($urandom_range(0, 15)) - 8;
                    bgoff = int'($urandom_range(0, 15)) - 8;
                end
                else
                begin
                    // Straddle the luma limits on green and on both offsets.
                    dg    = $urandom_range(0, 1) ? int'($urandom_range(30, 32))
                                                 : -int'($urandom_range(31, 33));
                    rgoff = $urandom_range(0, 1) ? int'($urandom_range(6, 8))
                                                 : -int'($urandom_range(7, 9));
                    bgoff = $urandom_range(0, 1) ? int'($urandom_range(6, 8))
                                                 : -int'($urandom_range(7, 9));
                end
                c.green = src_prev.green + 8'(dg);
                c.red   = src_prev.red   + 8'(dg + rgoff);
                c.blue  = src_prev.blue  + 8'(dg + bgoff);
            end
            PickRecall:
            begin
                if (recent.size() != 0)
                    c = recent[$urandom_range(0, recent.size() - 1)];
                else
                    c = rgb_t'($urandom_range(0, 24'hFF_FFFF));
            end
            default:
                c = rgb_t'($urandom_range(0, 24'hFF_FFFF));
        endcase
        return c;
    endfunction

    // Offer one pixel after a random gap; hold it until accepted.
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        rgb_t        c;
        if ($urandom_range(0, 24) == 0)
            calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix       <= px;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_pixel(px);
        pixels_sent++;
        // Advance the generator view; the last pixel returns it to reset.
        c = {px.red, px.green, px.blue};
        if (px.last_pixel)
        begin
            src_prev = '0;
            recent.delete();
        end
        else
        begin
            if (c != src_prev)
            begin
                recent.push_back(c);
                if (recent.size() > 8)
                    void'(recent.pop_front());
            end
            src_prev = c;
        end
    endtask

    // One image: a mix of runs, small and luma steps, palette recalls and noise,
    // closed by a marked last pixel.
    task automatic send_image(input int unsigned len, input bit lead_long_run);
        int unsigned k, reps, roll;
        pick_kind_t  kind;
        k = 0;
        while (k < len)
        begin
            roll = $urandom_range(0, 99);
            if (lead_long_run || roll < 20)
            begin
                if (lead_long_run || $urandom_range(0, 11) == 0)
                begin
                    reps = lead_long_run ? $urandom_range(62, 70) : $urandom_range(40, 70);
                    long_runs++;
                end
                else
                    reps = $urandom_range(1, 6);
                lead_long_run = 1'b0;
                if (k + reps > len)
                    len = k + reps;
                repeat (reps)
                begin
                    send_pixel(make_pixel(src_prev, k == len - 1));
                    k++;
                end
            end
            else
            begin
                kind = (roll < 40) ? PickDiff :
                       (roll < 60) ? PickLuma :
                       (roll < 70) ? PickEdge :
                       (roll < 85) ? PickRecall : PickAny;
                send_pixel(make_pixel(pick_colour(kind), k == len - 1));
                k++;
            end
        end
        images_sent++;
    endtask

    // Output side: stall a random number of cycles before each item, then take it.
    initial
    begin
        int unsigned gap;
        code_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                calm_out = !calm_out;
            gap = calm_out ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                code_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                code_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!code_valid);
            sb.check_code(code);
        end
    end

    // Main sequence.
    initial
    begin
        pix_valid <= 1'b0;
        pix       <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: black right after reset extends a run, since the previous
        // pixel resets to black.
        send_pixel(make_pixel(24'h000000, 1'b0));
        send_pixel(make_pixel(24'h000000, 1'b0));
        // Change flushes the run, then a small step.
        send_pixel(make_pixel(24'h010101, 1'b0));
        // Black hashes to a slot whose valid flag is clear: must not hit.
        send_pixel(make_pixel(24'h000000, 1'b0));
        // Both colours now sit in the index.
        send_pixel(make_pixel(24'h010101, 1'b0));
        send_pixel(make_pixel(24'h000000, 1'b0));
        // Wrap from 0 to 255 is a step of -1; 255 to 128 is out of range.
        send_pixel(make_pixel(24'hFFFFFF, 1'b0));
        send_pixel(make_pixel(24'h808080, 1'b0));
        // Luma green extremes, then red/blue offset extremes, then just past them.
        send_pixel(make_pixel(24'h606060, 1'b0));
        send_pixel(make_pixel(24'h7F7F7F, 1'b0));
        send_pixel(make_pixel(24'h7C8489, 1'b0));
        send_pixel(make_pixel(24'h838481, 1'b0));
        send_pixel(make_pixel(24'h8B8481, 1'b0));
        // Small step at its limits.
        send_pixel(make_pixel(24'h89857F, 1'b0));
        // Full-colour op, then a last pixel inside a run.
        send_pixel(make_pixel(24'hFF0080, 1'b0));
        send_pixel(make_pixel(24'hFF0080, 1'b1));
        // Single-pixel images: black (a run of one) and a luma step.
        send_pixel(make_pixel(24'h000000, 1'b1));
        send_pixel(make_pixel(24'h070707, 1'b1));
        // Index cleared by the last pixel: this must not hit, then close on a run.
        send_pixel(make_pixel(24'h010101, 1'b0));
        send_pixel(make_pixel(24'h010101, 1'b0));
        send_pixel(make_pixel(24'h010101, 1'b1));

        // Random images; the first opens with a run that reaches the flush limit.
        send_image($urandom_range(8, 40), 1'b1);
        while (pixels_sent < 205)
            send_image(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(8, 40), 1'b0);
        pix_valid <= 1'b0;

        // Drain, then give stray bytes time to show.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d pixels in %0d images (%0d long runs); checked %0d bytes,",
                 pixels_sent, images_sent, long_runs, sb.bytes_checked);
        $display("%0d byte mismatches.", sb.mismatches);
        if (sb.mismatches == 0)
            $display("[qoi_rgb_pixel_encoder_unit] OK");
        else
            $display("[qoi_rgb_pixel_encoder_unit] ERROR");
        $finish;
    end

endmodule
